FILE: src/ring_buffer_fence_allocator_assert.svh
// Assertion macros for the ring buffer fence allocator.
// Used by the controller and the top level; no other dependencies.
`ifndef RING_BUFFER_FENCE_ALLOCATOR_ASSERT_SVH
`define RING_BUFFER_FENCE_ALLOCATOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RBFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RBFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/rbfa_pkg.sv
// Package for the ring buffer fence allocator: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package rbfa_pkg;

  localparam int unsigned WatchDepthDefault = 64;
  localparam int unsigned OffW = 33;
  localparam logic [32:0] OffsetMax = 33'h1_FFFF_FFFF;

  localparam logic [1:0] CfgRingSize    = 2'd0;
  localparam logic [1:0] CfgNonCoherent = 2'd1;
  localparam logic [1:0] CfgUsageMode   = 2'd2;
  localparam logic [1:0] CfgAtomLog2    = 2'd3;

  localparam logic [1:0] ModeUpload   = 2'd0;
  localparam logic [1:0] ModeDownload = 2'd1;
  localparam logic [1:0] ModeStream   = 2'd2;

  localparam logic [1:0] MaintNone       = 2'd0;
  localparam logic [1:0] MaintFlush      = 2'd1;
  localparam logic [1:0] MaintInvalidate = 2'd2;

  localparam logic CmdReserve = 1'b0;
  localparam logic CmdCommit  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [3:0]  alignment_log2;
    logic        wait_ok;
    logic        sync_host;
    logic [63:0] current_tick;
    logic [63:0] completed_tick;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] grant_offset;
    logic        need_wait;
    logic [63:0] wait_tick;
    logic        drain_pending;
    logic [1:0]  maint_op;
    logic [31:0] maint_offset;
    logic [31:0] maint_size;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // capture input item
    logic prep;        // reserve: latch rounded size
    logic wrap;        // reserve: alignment and wrap decision
    logic scan_rd;     // read old-bank watch at scan index
    logic scan_step;   // evaluate the fetched watch
    logic fin_ok;      // emit granted reserve
    logic fin_fail;    // emit failed reserve
    logic fin_big;     // emit oversized reserve
    logic cm_rd;       // commit: read last watch
    logic cm_do;       // commit: update state and emit
  } cmd_t;

  typedef struct packed {
    logic is_commit;
    logic too_big;
    logic scan_more;
    logic tick_late;
    logic may_wait;
  } stat_t;

endpackage

FILE: src/rbfa_ctrl.sv
// Controller state machine of the ring buffer fence allocator.
// Depends on rbfa_pkg and ring_buffer_fence_allocator_assert.svh.
`timescale 1ns / 1ps
`include "ring_buffer_fence_allocator_assert.svh"
module rbfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rbfa_pkg::stat_t stat_i,
  output rbfa_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDec   = 8'b0000_0010,
    StWrap  = 8'b0000_0100,
    StRd    = 8'b0000_1000,
    StEval  = 8'b0001_0000,
    StCmRd  = 8'b0010_0000,
    StCmDo  = 8'b0100_0000,
    StCheck = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (stat_i.is_commit) begin
          cmd_o.cm_rd = 1'b1;
          state_d = StCmDo;
        end else begin
          cmd_o.prep = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.too_big) begin
          cmd_o.fin_big = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.wrap = 1'b1;
          state_d = StWrap;
        end
      end
      StWrap: begin
        if (stat_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
          state_d = StEval;
        end else begin
          cmd_o.fin_ok = 1'b1;
          state_d = StIdle;
        end
      end
      StEval: begin
        if (stat_i.tick_late && !stat_i.may_wait) begin
          cmd_o.fin_fail = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = StWrap;
        end
      end
      StCmDo: begin
        cmd_o.cm_do = 1'b1;
        state_d = StIdle;
      end
      StRd, StCmRd: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  `RBFA_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `RBFA_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, cmd_o.load, busy_o)
  `RBFA_ASSERT_IMP(a_eval_after_rd, clk_i, rst_ni, state_q == StEval, $past(cmd_o.scan_rd))

endmodule

FILE: src/rbfa_dp.sv
// Datapath of the ring buffer fence allocator: state registers, watch memory, results.
// Depends on rbfa_pkg.
`timescale 1ns / 1ps
module rbfa_dp #(
  parameter int unsigned WatchDepth = rbfa_pkg::WatchDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbfa_pkg::in_item_t in_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  rbfa_pkg::cmd_t    cmd_i,
  output rbfa_pkg::stat_t   stat_o,
  output logic              res_valid_o,
  output rbfa_pkg::out_item_t res_o
);

  localparam int unsigned IdxW = $clog2(WatchDepth);
  localparam int unsigned CntW = $clog2(WatchDepth + 1);
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned Depth2 = 1 << AddrW;

  logic [31:0] ring_size_q;
  logic        non_coh_q;
  logic [1:0]  mode_q;
  logic [3:0]  atom_q;

  rbfa_pkg::in_item_t item_q;
  logic [32:0] wr_off_q;
  logic [31:0] last_size_q;
  logic        bank_q;
  logic [CntW-1:0] wcount_q;
  logic        old_valid_q;
  logic [CntW-1:0] old_count_q;
  logic [CntW-1:0] scan_q;
  logic [32:0] rel_q;
  logic [32:0] size_q;
  logic [32:0] upper_q;
  logic        waited_q;
  logic        consumed_q;
  logic [63:0] max_tick_q;
  logic        res_valid_q;
  rbfa_pkg::out_item_t res_q;
  rbfa_pkg::out_item_t res_d;

  logic [32:0] bmem [Depth2];
  logic [63:0] tmem [Depth2];
  logic [32:0] rd_bound_q;
  logic [63:0] rd_tick_q;

  // Rounded size and the aligned write offset.
  logic [32:0] atom_m, size_rnd, align_m, off_al, off_al_sat;
  logic [33:0] off_al_sum;
  always_comb begin
    atom_m  = (33'd1 << atom_q) - 33'd1;
    size_rnd = {1'b0, item_q.request_size};
    if (non_coh_q && mode_q == rbfa_pkg::ModeStream) begin
      size_rnd = ({1'b0, item_q.request_size} + atom_m) & ~atom_m;
    end
    align_m = (33'd1 << item_q.alignment_log2) - 33'd1;
    off_al_sum = {1'b0, wr_off_q} + {1'b0, align_m};
    off_al = off_al_sum[32:0] & ~align_m;
    off_al_sat = off_al_sum[33] ? rbfa_pkg::OffsetMax : off_al;
  end

  // The wrap decision looks at the offset after alignment.
  logic [32:0] off_now;
  logic [33:0] wrap_sum;
  logic        do_wrap;
  assign off_now  = (item_q.alignment_log2 != 4'd0) ? off_al_sat : wr_off_q;
  assign wrap_sum = {1'b0, off_now} + {1'b0, size_q};
  assign do_wrap  = wrap_sum > {2'b0, ring_size_q};

  logic [AddrW-1:0] old_addr, new_addr;
  logic [CntW-1:0]  last_slot;
  assign old_addr = {~bank_q, scan_q[IdxW-1:0]};
  assign last_slot = wcount_q - CntW'(1);
  assign new_addr  = {bank_q, last_slot[IdxW-1:0]};

  logic [33:0] adv_sum;
  logic [32:0] new_off;
  assign adv_sum = {1'b0, wr_off_q} + {2'b0, last_size_q};
  assign new_off = adv_sum[33] || adv_sum[32:0] > rbfa_pkg::OffsetMax ?
                   rbfa_pkg::OffsetMax : adv_sum[32:0];

  logic merge;
  logic [AddrW-1:0] put_addr;
  logic [CntW-1:0] put_slot;
  always_comb begin
    merge = (wcount_q != '0) && (rd_tick_q == item_q.current_tick);
    if (wcount_q >= CntW'(WatchDepth)) put_slot = CntW'(WatchDepth - 1);
    else put_slot = wcount_q;
    put_addr = {bank_q, put_slot[IdxW-1:0]};
  end

  assign stat_o.is_commit = item_q.command == rbfa_pkg::CmdCommit;
  assign stat_o.too_big   = size_q > {1'b0, ring_size_q};
  assign stat_o.scan_more = old_valid_q && upper_q > rel_q && scan_q < old_count_q;
  assign stat_o.tick_late = rd_tick_q > item_q.completed_tick;
  assign stat_o.may_wait  = item_q.wait_ok;

  logic drain;
  assign drain = mode_q == rbfa_pkg::ModeDownload && consumed_q;

  logic fin_any;
  assign fin_any = cmd_i.fin_ok | cmd_i.fin_fail | cmd_i.fin_big | cmd_i.cm_do;

  always_comb begin
    res_d = '0;
    if (cmd_i.fin_ok) begin
      res_d.granted       = 1'b1;
      res_d.grant_offset  = wr_off_q[31:0];
      res_d.need_wait     = waited_q;
      res_d.wait_tick     = max_tick_q;
      res_d.drain_pending = drain;
    end
    if (cmd_i.fin_fail) res_d.drain_pending = drain;
    if (cmd_i.cm_do) begin
      res_d.granted      = 1'b1;
      res_d.grant_offset = new_off[31:0];
      if (item_q.sync_host && non_coh_q) begin
        res_d.maint_op = (mode_q == rbfa_pkg::ModeDownload) ?
                         rbfa_pkg::MaintInvalidate : rbfa_pkg::MaintFlush;
        res_d.maint_offset = wr_off_q[31:0];
        res_d.maint_size   = last_size_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_bound_q <= bmem[old_addr];
      rd_tick_q  <= tmem[old_addr];
    end else if (cmd_i.cm_rd) begin
      rd_tick_q  <= tmem[new_addr];
    end
    if (cmd_i.cm_do) begin
      if (merge) begin
        bmem[new_addr] <= new_off;
      end else begin
        bmem[put_addr] <= new_off;
        tmem[put_addr] <= item_q.current_tick;
      end
    end
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.prep) size_q <= size_rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= 32'd65536;
      non_coh_q   <= 1'b0;
      mode_q      <= rbfa_pkg::ModeUpload;
      atom_q      <= 4'd6;
      wr_off_q    <= '0;
      last_size_q <= '0;
      bank_q      <= 1'b0;
      wcount_q    <= '0;
      old_valid_q <= 1'b0;
      old_count_q <= '0;
      scan_q      <= '0;
      rel_q       <= '0;
      upper_q     <= '0;
      waited_q    <= 1'b0;
      consumed_q  <= 1'b0;
      max_tick_q  <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= fin_any;
      if (fin_any) res_q <= res_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rbfa_pkg::CfgRingSize:    ring_size_q <= cfg_data_i;
          rbfa_pkg::CfgNonCoherent: non_coh_q   <= cfg_data_i[0];
          rbfa_pkg::CfgUsageMode:   mode_q      <= cfg_data_i[1:0];
          rbfa_pkg::CfgAtomLog2:    atom_q      <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        waited_q   <= 1'b0;
        consumed_q <= 1'b0;
        max_tick_q <= '0;
      end
      // Alignment and the wrap are applied together once the size is known to fit.
      if (cmd_i.wrap) begin
        last_size_q <= size_q[31:0];
        if (do_wrap) begin
          old_count_q <= wcount_q;
          old_valid_q <= 1'b1;
          wcount_q    <= '0;
          wr_off_q    <= '0;
          bank_q      <= ~bank_q;
          scan_q      <= '0;
          rel_q       <= '0;
          upper_q     <= size_q;
        end else begin
          wr_off_q <= off_now;
          upper_q  <= wrap_sum[32:0];
        end
      end
      if (cmd_i.scan_step) begin
        consumed_q <= 1'b1;
        rel_q      <= rd_bound_q;
        scan_q     <= scan_q + CntW'(1);
        if (stat_o.tick_late) begin
          waited_q <= 1'b1;
          if (rd_tick_q > max_tick_q) max_tick_q <= rd_tick_q;
        end
      end
      if (cmd_i.cm_do) begin
        wr_off_q <= new_off;
        if (!merge) begin
          if (wcount_q < CntW'(WatchDepth)) wcount_q <= wcount_q + CntW'(1);
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

endmodule

FILE: src/ring_buffer_fence_allocator.sv
// Top level of the ring buffer fence allocator.
// Depends on rbfa_pkg, rbfa_ctrl, rbfa_dp and the assertion header.
//
// channel   direction  handshake
// item in   input      start while busy low
// result    output     done_o strobe, one cycle
// config    input      cfg_we_i, any time idle
//
// From one accepted item to the next: a commit passes Idle, Dec and CmDo; an oversized
// reserve Idle, Dec and Check; a granted reserve also Wrap, plus one Eval and Wrap
// visit per watch consumed from the old bank; a failed reserve ends in Eval. Each scan
// step is one watch memory read and one compare. done_o rises in the cycle in which busy falls.
// Reset clears all control state; watch memory is not cleared.
// The result receiver cannot stall.
`timescale 1ns / 1ps
`include "ring_buffer_fence_allocator_assert.svh"
module ring_buffer_fence_allocator #(
  parameter int unsigned WatchDepth = rbfa_pkg::WatchDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rbfa_pkg::in_item_t in_item_i,
  output logic               done_o,
  output rbfa_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  rbfa_pkg::cmd_t  cmd;
  rbfa_pkg::stat_t stat;

  rbfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd), .busy_o(busy)
  );

  rbfa_dp #(.WatchDepth(WatchDepth)) u_dp (
    .clk_i, .rst_ni, .in_i(in_item_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .stat_o(stat), .res_valid_o(done_o), .res_o(out_item_o)
  );

  `RBFA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `RBFA_ASSERT_IMP(a_done_one, clk_i, rst_ni, done_o, !$past(done_o))
  `RBFA_ASSERT_IMP(a_fail_nowait, clk_i, rst_ni, done_o && !out_item_o.granted,
                   !out_item_o.need_wait)

endmodule

FILE: verif/ring_buffer_fence_allocator_tb.sv
// Self-checking testbench for the ring buffer fence allocator.
// Depends on rbfa_pkg and the ring_buffer_fence_allocator top level.
`timescale 1ns / 1ps
module ring_buffer_fence_allocator_tb;

  localparam int unsigned Depth = 64;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned RandItems = 1250;

  typedef struct {
    bit                  is_cfg;
    logic [1:0]          idx;
    logic [31:0]         data;
    rbfa_pkg::in_item_t  item;
    bit                  typed;
    rbfa_pkg::out_item_t res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  rbfa_pkg::in_item_t  in_item_i = '0;
  logic                done_o;
  rbfa_pkg::out_item_t out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [31:0]         cfg_data_i = '0;

  ring_buffer_fence_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .done_o, .out_item_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Predictor copy of configuration and allocator state.
  logic [31:0] ring_sz;
  logic        nc_en;
  logic [1:0]  mode;
  logic [3:0]  atom_lg;
  logic [32:0] wofs;
  logic [31:0] last_size;
  logic        bank;
  int unsigned wcount, old_count, scan_idx;
  logic        old_valid;
  logic [32:0] rel_bound;
  logic [32:0] wbound [2*Depth];
  logic [63:0] wtick [2*Depth];

  rbfa_pkg::out_item_t alloc_q [$];
  bit          failed = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned stall_cnt = 0;
  stim_row_t   rows [$];

  function automatic logic [32:0] sat33(logic [63:0] v);
    return (v > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : v[32:0];
  endfunction

  function automatic rbfa_pkg::out_item_t alloc_reserve(rbfa_pkg::in_item_t it);
    rbfa_pkg::out_item_t r;
    logic [63:0] size, atom, a, upper, t, max_tick;
    bit          waited, consumed;
    int unsigned base;
    r = '0;
    size = {32'd0, it.request_size};
    waited = 1'b0;
    consumed = 1'b0;
    max_tick = '0;
    if (nc_en && mode == rbfa_pkg::ModeStream) begin
      atom = 64'd1 << atom_lg;
      size = (size + atom - 1) & ~(atom - 1);
    end
    if (size > {32'd0, ring_sz}) return r;
    last_size = size[31:0];
    if (it.alignment_log2 != 0) begin
      a = 64'd1 << it.alignment_log2;
      wofs = sat33(({31'd0, wofs} + a - 1) & ~(a - 1));
    end
    if ({31'd0, wofs} + size > {32'd0, ring_sz}) begin
      old_count = wcount;
      old_valid = 1'b1;
      wcount = 0;
      wofs = '0;
      bank = ~bank;
      scan_idx = 0;
      rel_bound = '0;
    end
    upper = {31'd0, wofs} + size;
    base = (bank ? 0 : 1) * Depth;
    if (old_valid) begin
      while (upper > {31'd0, rel_bound} && scan_idx < old_count && scan_idx < Depth) begin
        t = wtick[base + scan_idx];
        if (t > it.completed_tick) begin
          if (!it.wait_ok) begin
            r.drain_pending = (mode == rbfa_pkg::ModeDownload) && consumed;
            return r;
          end
          waited = 1'b1;
          if (t > max_tick) max_tick = t;
        end
        consumed = 1'b1;
        rel_bound = wbound[base + scan_idx];
        scan_idx++;
      end
    end
    r.granted = 1'b1;
    r.grant_offset = wofs[31:0];
    r.need_wait = waited;
    r.wait_tick = max_tick;
    r.drain_pending = (mode == rbfa_pkg::ModeDownload) && consumed;
    return r;
  endfunction

  function automatic rbfa_pkg::out_item_t alloc_commit(rbfa_pkg::in_item_t it);
    rbfa_pkg::out_item_t r;
    int unsigned base, slot;
    r = '0;
    base = (bank ? 1 : 0) * Depth;
    if (it.sync_host && nc_en) begin
      r.maint_op = (mode == rbfa_pkg::ModeDownload) ? rbfa_pkg::MaintInvalidate :
                                                      rbfa_pkg::MaintFlush;
      r.maint_offset = wofs[31:0];
      r.maint_size = last_size;
    end
    wofs = sat33({31'd0, wofs} + {32'd0, last_size});
    if (wcount != 0 && wcount <= Depth && wtick[base + wcount - 1] == it.current_tick) begin
      wbound[base + wcount - 1] = wofs;
    end else begin
      if (wcount >= Depth) begin
        slot = Depth - 1;
        wcount = Depth;
      end else begin
        slot = wcount;
        wcount++;
      end
      wbound[base + slot] = wofs;
      wtick[base + slot] = it.current_tick;
    end
    r.granted = 1'b1;
    r.grant_offset = wofs[31:0];
    return r;
  endfunction

  task automatic wait_drained();
    while (alloc_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      rbfa_pkg::CfgRingSize:    ring_sz = data;
      rbfa_pkg::CfgNonCoherent: nc_en = data[0];
      rbfa_pkg::CfgUsageMode:   mode = data[1:0];
      default:                  atom_lg = data[3:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the item on the bus until the block takes it, then drops start.
  task automatic send_item(rbfa_pkg::in_item_t it, bit typed, rbfa_pkg::out_item_t res);
    rbfa_pkg::out_item_t p;
    int unsigned gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 36) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    p = it.command == rbfa_pkg::CmdCommit ? alloc_commit(it) : alloc_reserve(it);
    alloc_q.push_back(typed ? res : p);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  function automatic rbfa_pkg::in_item_t rsv(logic [31:0] sz, logic [3:0] al, logic aw,
                                             logic [63:0] comp);
    rbfa_pkg::in_item_t it;
    it = '0;
    it.command = rbfa_pkg::CmdReserve;
    it.request_size = sz;
    it.alignment_log2 = al;
    it.wait_ok = aw;
    it.completed_tick = comp;
    it.current_tick = {$urandom, $urandom};
    return it;
  endfunction

  function automatic rbfa_pkg::in_item_t cmt(logic fl, logic [63:0] tick);
    rbfa_pkg::in_item_t it;
    it = '0;
    it.command = rbfa_pkg::CmdCommit;
    it.sync_host = fl;
    it.current_tick = tick;
    it.request_size = $urandom;
    it.completed_tick = {$urandom, $urandom};
    return it;
  endfunction

  task automatic add_item(rbfa_pkg::in_item_t it);
    stim_row_t r;
    r = '{default: '0};
    r.item = it;
    rows.push_back(r);
  endtask

  task automatic add_typed(rbfa_pkg::in_item_t it, rbfa_pkg::out_item_t res);
    stim_row_t r;
    r = '{default: '0};
    r.item = it;
    r.typed = 1'b1;
    r.res = res;
    rows.push_back(r);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    rbfa_pkg::out_item_t e;
    if (rst_ni && done_o) begin
      if (alloc_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item_o);
        failed = 1'b1;
      end else begin
        e = alloc_q.pop_front();
        if (out_item_o.granted !== e.granted || out_item_o.grant_offset !== e.grant_offset ||
            out_item_o.need_wait !== e.need_wait || out_item_o.wait_tick !== e.wait_tick ||
            out_item_o.drain_pending !== e.drain_pending ||
            out_item_o.maint_op !== e.maint_op || out_item_o.maint_offset !== e.maint_offset ||
            out_item_o.maint_size !== e.maint_size) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rbfa_pkg::out_item_t zero_res, res;
    rbfa_pkg::in_item_t  it;
    logic [63:0] tick_base, cur, comp;
    logic [31:0] cap;
    int unsigned n, pick;
    zero_res = '0;
    ring_sz = 32'd65536;
    nc_en = 1'b0;
    mode = rbfa_pkg::ModeUpload;
    atom_lg = 4'd6;
    wofs = '0;
    last_size = '0;
    bank = 1'b0;
    wcount = 0;
    old_count = 0;
    scan_idx = 0;
    old_valid = 1'b0;
    rel_bound = '0;

    // Directed table.
    add_typed(rsv(32'h0001_0001, 4'd0, 1'b1, 64'd0), zero_res);
    res = '0;
    res.granted = 1'b1;
    add_typed(rsv(32'd0, 4'd0, 1'b0, 64'd0), res);
    add_item(rsv(32'd100, 4'd4, 1'b1, 64'd0));
    add_item(cmt(1'b1, 64'd5));
    add_item(rsv(32'd65536, 4'd0, 1'b0, 64'd3));
    add_item(rsv(32'd65536, 4'd0, 1'b1, 64'd3));
    add_item(cmt(1'b0, 64'd6));
    add_cfg(rbfa_pkg::CfgNonCoherent, 32'd1);
    add_cfg(rbfa_pkg::CfgUsageMode, {30'd0, rbfa_pkg::ModeDownload});
    add_item(rsv(32'd64, 4'd12, 1'b1, 64'd0));
    add_item(cmt(1'b1, 64'd7));
    add_cfg(rbfa_pkg::CfgUsageMode, {30'd0, rbfa_pkg::ModeStream});
    add_cfg(rbfa_pkg::CfgAtomLog2, 32'd12);
    add_item(rsv(32'd1, 4'd0, 1'b1, 64'd1));
    add_item(cmt(1'b1, 64'd8));
    add_cfg(rbfa_pkg::CfgRingSize, 32'hFFFF_FFFF);
    add_cfg(rbfa_pkg::CfgUsageMode, 32'd3);
    add_item(rsv(32'hFFFF_FFFF, 4'd0, 1'b1, 64'd0));
    add_item(cmt(1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    add_item(cmt(1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
    add_item(cmt(1'b1, 64'd9));
    add_item(rsv(32'd1, 4'd12, 1'b1, 64'd0));
    add_item(rsv(32'hFFFF_FFFF, 4'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
    add_cfg(rbfa_pkg::CfgRingSize, 32'd1);
    add_typed(rsv(32'd2, 4'd0, 1'b1, 64'd0), zero_res);
    add_item(rsv(32'd1, 4'd0, 1'b0, 64'd0));
    add_item(cmt(1'b0, 64'd10));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_item(rows[i].item, rows[i].typed, rows[i].res);
    end

    // Random phases: mostly reserve/commit pairs with rising ticks.
    n = 0;
    while (n < RandItems) begin
      pick = $urandom_range(5);
      case (pick)
        0: write_reg(rbfa_pkg::CfgRingSize, 32'd1);
        1: write_reg(rbfa_pkg::CfgRingSize, 32'hFFFF_FFFF);
        2: write_reg(rbfa_pkg::CfgRingSize, $urandom_range(256, 8192));
        default: write_reg(rbfa_pkg::CfgRingSize, $urandom_range(16384, 262144));
      endcase
      write_reg(rbfa_pkg::CfgNonCoherent, $urandom_range(1));
      write_reg(rbfa_pkg::CfgUsageMode, $urandom_range(3));
      write_reg(rbfa_pkg::CfgAtomLog2, $urandom_range(12));
      cap = (ring_sz > 32'd16) ? ring_sz >> $urandom_range(2, 5) : ring_sz;
      tick_base = {$urandom, $urandom};
      cur = tick_base;
      repeat (150) begin
        if (n >= RandItems) break;
        no_idle = (n >= 500 && n < 700);
        comp = cur - $urandom_range(0, 80);
        if ($urandom_range(9) == 0) comp = {$urandom, $urandom};
        if ($urandom_range(19) == 0) it = rsv($urandom, 4'($urandom_range(12)),
                                              1'($urandom_range(1)), comp);
        else it = rsv($urandom_range(0, cap), 4'($urandom_range(12)),
                      $urandom_range(9) != 0, comp);
        send_item(it, 1'b0, zero_res);
        n++;
        if ($urandom_range(7) != 0) begin
          if ($urandom_range(9) < 7) cur = cur + 1;
          send_item(cmt(1'($urandom_range(1)), cur), 1'b0, zero_res);
          n++;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
